// ===== rtl/rrsa_pkg.sv =====
// shared constants, codes and control types of the slot allocator
package rrsa_pkg;

   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int OWNER_W   = 16;
   localparam int PROTO_W   = 2;
   localparam int GRANT_W   = 3;
   localparam int ENTRY_W   = OWNER_W + PROTO_W;

   localparam logic [OWNER_W-1:0] NO_OWNER = {OWNER_W{1'b1}};

   // request kinds
   localparam logic [1:0] KIND_ALLOC = 2'd0;
   localparam logic [1:0] KIND_FREE  = 2'd1;
   localparam logic [1:0] KIND_CHECK = 2'd2;
   localparam logic [1:0] KIND_QUERY = 2'd3;

   // protocol codes
   localparam logic [PROTO_W-1:0] PROTO_NONE   = 2'd0;
   localparam logic [PROTO_W-1:0] PROTO_UNUSED = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic              load;
      logic              step;
      logic [SLOT_W-1:0] start;
   } scan_ctl_type;

   typedef struct packed {
      logic              hit;
      logic              miss;
      logic [SLOT_W-1:0] idx;
      logic [SLOT_W-1:0] idx_next;
   } scan_sts_type;

endpackage

// ===== rtl/rrsa_ram.sv =====
// generic single-write, single-read ram with registered read data
module rrsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rrsa_scan.sv =====
// next-fit scan unit: tests one slot per cycle, wrapping around the table
module rrsa_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  rrsa_pkg::scan_ctl_type        ctl,
   input  logic [rrsa_pkg::NUM_SLOTS-1:0] active,
   output rrsa_pkg::scan_sts_type        sts
);

   logic [rrsa_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic [rrsa_pkg::SLOT_W-1:0] count_ff, count_in;
   logic [rrsa_pkg::SLOT_W-1:0] idx_next;
   logic                        last_slot;

   // wrap after the highest slot
   assign idx_next  = (idx_ff == rrsa_pkg::SLOT_W'(rrsa_pkg::NUM_SLOTS - 1))
                      ? '0 : idx_ff + 1'b1;
   assign last_slot = (count_ff == rrsa_pkg::SLOT_W'(rrsa_pkg::NUM_SLOTS - 1));

   always_comb begin
      idx_in   = idx_ff;
      count_in = count_ff;
      if (ctl.load) begin
         idx_in   = ctl.start;
         count_in = '0;
      end else if (ctl.step) begin
         idx_in   = idx_next;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   assign sts.hit      = !active[idx_ff];
   assign sts.miss     = active[idx_ff] && last_slot;
   assign sts.idx      = idx_ff;
   assign sts.idx_next = idx_next;

endmodule

// ===== rtl/round_robin_slot_allocator.sv =====
// top level of the next-fit connection slot allocator
//
// A table of connection slots, each with an active bit, a 16-bit owner and a
// 2-bit protocol. An item is taken when start is high and busy is low; the
// block then holds busy high until the item is done. Free, check and query
// do one ram read. Allocate scans one slot per cycle starting after the last
// granted slot until a slot is free or all were tested: the scan unit tests
// a single active bit each cycle. The result shows on the rsp_ ports for
// exactly one cycle with rsp_valid high, in the cycle in which busy falls;
// the receiver cannot stall it, and a new item may be started in that same
// cycle. Out-of-range slots on free, check and query give the invalid
// status and leave the table alone. The owner and protocol sit in a ram; an
// inactive slot reads as no owner and protocol none, so reset needs no pass.
module round_robin_slot_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_client,
   input  logic [1:0]  req_protocol,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_granted_slot,
   output logic        rsp_slot_active,
   output logic [15:0] rsp_slot_owner,
   output logic [1:0]  rsp_slot_protocol
);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_LOOK = 2'd2;

   logic [1:0] state_ff, state_in;

   // latched item
   logic [1:0]                     kind_ff, kind_in;
   logic [rrsa_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic                           valid_ff, valid_in;
   logic [rrsa_pkg::OWNER_W-1:0]   client_ff, client_in;
   logic [rrsa_pkg::PROTO_W-1:0]   proto_ff, proto_in;

   // table state
   logic [rrsa_pkg::NUM_SLOTS-1:0] active_ff, active_in;
   logic [rrsa_pkg::SLOT_W-1:0]    search_start_ff, search_start_in;

   // result registers
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     status_ff, status_in;
   logic [rrsa_pkg::GRANT_W-1:0]   granted_ff, granted_in;
   logic                           act_ff, act_in;
   logic [rrsa_pkg::OWNER_W-1:0]   owner_ff, owner_in;
   logic [rrsa_pkg::PROTO_W-1:0]   prt_ff, prt_in;

   logic                           accept;
   logic                           req_valid;
   logic [rrsa_pkg::SLOT_W-1:0]    req_idx;

   rrsa_pkg::scan_ctl_type         scan_ctl;
   rrsa_pkg::scan_sts_type         scan_sts;

   logic                           ram_wr_en;
   logic [rrsa_pkg::ENTRY_W-1:0]   ram_wr_data;
   logic [rrsa_pkg::SLOT_W-1:0]    ram_rd_addr;
   logic [rrsa_pkg::ENTRY_W-1:0]   ram_rd_data;
   logic [rrsa_pkg::OWNER_W-1:0]   ram_owner;
   logic [rrsa_pkg::PROTO_W-1:0]   ram_proto;
   logic                           look_active;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign req_valid = (int'(req_slot) < rrsa_pkg::NUM_SLOTS);
   assign req_idx   = rrsa_pkg::SLOT_W'(req_slot);

   // ram read is issued at the accepting edge, data is ready in the look state
   assign ram_rd_addr = busy ? slot_ff : req_idx;
   assign ram_owner   = ram_rd_data[rrsa_pkg::ENTRY_W-1:rrsa_pkg::PROTO_W];
   assign ram_proto   = ram_rd_data[rrsa_pkg::PROTO_W-1:0];
   assign look_active = valid_ff && active_ff[slot_ff];

   // the scan is armed whenever an item is accepted; only allocate goes on to scan
   assign scan_ctl.load  = accept;
   assign scan_ctl.step  = (state_ff == ST_SCAN);
   assign scan_ctl.start = search_start_ff;

   rrsa_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .ctl    (scan_ctl),
      .active (active_ff),
      .sts    (scan_sts)
   );

   // owner and protocol written on a successful allocate only
   assign ram_wr_en   = (state_ff == ST_SCAN) && scan_sts.hit;
   assign ram_wr_data = {client_ff, proto_ff};

   rrsa_ram #(
      .WIDTH (rrsa_pkg::ENTRY_W),
      .DEPTH (rrsa_pkg::NUM_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (scan_sts.idx),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      slot_in         = slot_ff;
      valid_in        = valid_ff;
      client_in       = client_ff;
      proto_in        = proto_ff;
      active_in       = active_ff;
      search_start_in = search_start_ff;
      rsp_valid_in    = 1'b0;
      status_in       = status_ff;
      granted_in      = granted_ff;
      act_in          = act_ff;
      owner_in        = owner_ff;
      prt_in          = prt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in   = req_kind;
               slot_in   = req_idx;
               valid_in  = req_valid;
               client_in = req_client;
               // unused protocol code is stored as none
               proto_in  = (req_protocol == rrsa_pkg::PROTO_UNUSED)
                           ? rrsa_pkg::PROTO_NONE : req_protocol;
               state_in  = (req_kind == rrsa_pkg::KIND_ALLOC) ? ST_SCAN : ST_LOOK;
            end
         end
         ST_SCAN: begin
            if (scan_sts.hit || scan_sts.miss) begin
               rsp_valid_in = 1'b1;
               act_in       = 1'b0;
               owner_in     = rrsa_pkg::NO_OWNER;
               prt_in       = rrsa_pkg::PROTO_NONE;
               state_in     = ST_IDLE;
               if (scan_sts.hit) begin
                  active_in[scan_sts.idx] = 1'b1;
                  search_start_in         = scan_sts.idx_next;
                  status_in               = rrsa_pkg::STATUS_OK;
                  granted_in              = rrsa_pkg::GRANT_W'(scan_sts.idx);
               end else begin
                  // table full, next-fit pointer stays
                  status_in  = rrsa_pkg::STATUS_FULL;
                  granted_in = '0;
               end
            end
         end
         ST_LOOK: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            status_in    = valid_ff ? rrsa_pkg::STATUS_OK : rrsa_pkg::STATUS_INVALID;
            granted_in   = '0;
            act_in       = 1'b0;
            owner_in     = rrsa_pkg::NO_OWNER;
            prt_in       = rrsa_pkg::PROTO_NONE;
            case (kind_ff)
               rrsa_pkg::KIND_FREE: begin
                  // clearing the active bit returns the slot to reset contents
                  if (valid_ff) begin
                     active_in[slot_ff] = 1'b0;
                  end
               end
               rrsa_pkg::KIND_CHECK: begin
                  // a free slot never matches
                  if (look_active && (ram_owner == client_ff)) begin
                     status_in  = rrsa_pkg::STATUS_OK;
                     granted_in = rrsa_pkg::GRANT_W'(slot_ff);
                  end else begin
                     status_in  = rrsa_pkg::STATUS_INVALID;
                  end
               end
               rrsa_pkg::KIND_QUERY: begin
                  // inactive slot reads as no owner, protocol none
                  if (look_active) begin
                     act_in   = 1'b1;
                     owner_in = ram_owner;
                     prt_in   = ram_proto;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_ff       <= '0;
         search_start_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         active_ff       <= active_in;
         search_start_ff <= search_start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      slot_ff    <= slot_in;
      valid_ff   <= valid_in;
      client_ff  <= client_in;
      proto_ff   <= proto_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      act_ff     <= act_in;
      owner_ff   <= owner_in;
      prt_ff     <= prt_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_granted_slot  = granted_ff;
   assign rsp_slot_active   = act_ff;
   assign rsp_slot_owner    = owner_ff;
   assign rsp_slot_protocol = prt_ff;

endmodule

// ===== dv/round_robin_slot_allocator_tb.sv =====
// testbench for the next-fit connection slot allocator
`timescale 1ns / 1ps

module round_robin_slot_allocator_tb;

   // one result as the block reports it
   typedef struct packed {
      logic [1:0]                   status;
      logic [rrsa_pkg::GRANT_W-1:0] granted;
      logic                         active;
      logic [rrsa_pkg::OWNER_W-1:0] owner;
      logic [rrsa_pkg::PROTO_W-1:0] proto;
   } slot_rsp_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [3:0]  req_slot;
   logic [15:0] req_client;
   logic [1:0]  req_protocol;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_granted_slot;
   logic        rsp_slot_active;
   logic [15:0] rsp_slot_owner;
   logic [1:0]  rsp_slot_protocol;

   // private copy of the slot table, updated as each item is accepted
   logic                         table_active [rrsa_pkg::NUM_SLOTS] = '{default: 1'b0};
   logic [rrsa_pkg::OWNER_W-1:0] table_owner  [rrsa_pkg::NUM_SLOTS] =
      '{default: rrsa_pkg::NO_OWNER};
   logic [rrsa_pkg::PROTO_W-1:0] table_proto  [rrsa_pkg::NUM_SLOTS] =
      '{default: rrsa_pkg::PROTO_NONE};
   int                           next_scan = 0;

   // results still owed by the block, oldest first
   slot_rsp_type owed_rsp [$];
   int           mismatches = 0;

   round_robin_slot_allocator uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_slot          (req_slot),
      .req_client        (req_client),
      .req_protocol      (req_protocol),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_granted_slot  (rsp_granted_slot),
      .rsp_slot_active   (rsp_slot_active),
      .rsp_slot_owner    (rsp_slot_owner),
      .rsp_slot_protocol (rsp_slot_protocol)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // applies one item to the private table and returns the result it must give
   function automatic slot_rsp_type apply_to_slot_table(logic [1:0] kind, logic [3:0] slot,
                                                        logic [15:0] client, logic [1:0] proto);
      slot_rsp_type                 r;
      logic                         in_range;
      logic                         found;
      logic [rrsa_pkg::PROTO_W-1:0] stored_proto;
      logic [rrsa_pkg::SLOT_W-1:0]  si;
      int                           idx;
      r = '{status: rrsa_pkg::STATUS_OK, granted: '0, active: 1'b0,
            owner: rrsa_pkg::NO_OWNER, proto: rrsa_pkg::PROTO_NONE};
      in_range = (slot < rrsa_pkg::NUM_SLOTS);
      si = slot[rrsa_pkg::SLOT_W-1:0];
      // the unused protocol code is kept as none
      stored_proto = (proto == rrsa_pkg::PROTO_UNUSED) ? rrsa_pkg::PROTO_NONE : proto;
      found = 1'b0;
      idx = 0;
      case (kind)
         rrsa_pkg::KIND_ALLOC: begin
            // next fit: first inactive slot from the scan point, wrapping around
            for (int i = 0; i < rrsa_pkg::NUM_SLOTS && !found; i++) begin
               idx = (next_scan + i) % rrsa_pkg::NUM_SLOTS;
               if (!table_active[idx])
                  found = 1'b1;
            end
            if (found) begin
               table_active[idx] = 1'b1;
               table_owner[idx] = client;
               table_proto[idx] = stored_proto;
               next_scan = (idx + 1) % rrsa_pkg::NUM_SLOTS;
               r.granted = rrsa_pkg::GRANT_W'(idx);
            end else begin
               // table full, scan point stays put
               r.status = rrsa_pkg::STATUS_FULL;
            end
         end
         rrsa_pkg::KIND_FREE: begin
            // freeing an inactive slot is fine and just clears it again
            if (in_range) begin
               table_active[si] = 1'b0;
               table_owner[si] = rrsa_pkg::NO_OWNER;
               table_proto[si] = rrsa_pkg::PROTO_NONE;
            end else begin
               r.status = rrsa_pkg::STATUS_INVALID;
            end
         end
         rrsa_pkg::KIND_CHECK: begin
            // a free slot never matches, not even the no-owner client
            if (in_range && table_active[si] && table_owner[si] == client)
               r.granted = rrsa_pkg::GRANT_W'(si);
            else
               r.status = rrsa_pkg::STATUS_INVALID;
         end
         default: begin
            if (in_range) begin
               r.active = table_active[si];
               r.owner = table_owner[si];
               r.proto = table_proto[si];
            end else begin
               r.status = rrsa_pkg::STATUS_INVALID;
            end
         end
      endcase
      return r;
   endfunction

   // drives one item from the falling edge and holds it until the block takes it;
   // start stays high afterwards so the next item can follow without a gap
   task automatic send_item(logic [1:0] kind, logic [3:0] slot,
                            logic [15:0] client, logic [1:0] proto);
      @(negedge clock);
      start = 1'b1;
      req_kind = kind;
      req_slot = slot;
      req_client = client;
      req_protocol = proto;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      // taken at this edge
      owed_rsp.push_back(apply_to_slot_table(kind, slot, client, proto));
   endtask

   // holds start low, with junk on the request fields meanwhile
   task automatic hold_off(int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
         req_kind = 2'($urandom);
         req_slot = 4'($urandom);
         req_client = 16'($urandom);
         req_protocol = 2'($urandom);
      end
   endtask

   // one random item, mostly in-range slots and often the real owner on checks
   task automatic send_random_item();
      int          roll;
      logic [1:0]  kind;
      logic [3:0]  slot;
      logic [15:0] client;
      roll = $urandom_range(0, 99);
      if (roll < 30)
         kind = rrsa_pkg::KIND_ALLOC;
      else if (roll < 55)
         kind = rrsa_pkg::KIND_FREE;
      else if (roll < 75)
         kind = rrsa_pkg::KIND_CHECK;
      else
         kind = rrsa_pkg::KIND_QUERY;
      if ($urandom_range(0, 9) == 0)
         slot = 4'($urandom_range(rrsa_pkg::NUM_SLOTS, 15));
      else
         slot = 4'($urandom_range(0, rrsa_pkg::NUM_SLOTS - 1));
      case ($urandom_range(0, 3))
         0: client = (slot < rrsa_pkg::NUM_SLOTS) ?
                     table_owner[slot[rrsa_pkg::SLOT_W-1:0]] : rrsa_pkg::NO_OWNER;
         1: client = ($urandom_range(0, 1) == 0) ? 16'h0000 : rrsa_pkg::NO_OWNER;
         2: client = 16'($urandom_range(0, 3));
         default: client = 16'($urandom);
      endcase
      send_item(kind, slot, client, 2'($urandom_range(0, 3)));
   endtask

   // reset contents and out-of-range queries
   task automatic test_reset_contents();
      send_item(rrsa_pkg::KIND_QUERY, 4'd0, 16'h0000, 2'd0);
      send_item(rrsa_pkg::KIND_QUERY, 4'(rrsa_pkg::NUM_SLOTS - 1), 16'hffff, 2'd3);
      send_item(rrsa_pkg::KIND_QUERY, 4'(rrsa_pkg::NUM_SLOTS), 16'h0000, 2'd0);
      send_item(rrsa_pkg::KIND_QUERY, 4'd15, 16'hffff, 2'd3);
   endtask

   // field extremes on allocate, including the unused protocol code
   task automatic test_allocate_fields();
      send_item(rrsa_pkg::KIND_ALLOC, 4'd15, 16'h0000, rrsa_pkg::PROTO_UNUSED);
      send_item(rrsa_pkg::KIND_ALLOC, 4'd0, 16'hffff, 2'd1);
      send_item(rrsa_pkg::KIND_ALLOC, 4'd7, 16'h8001, 2'd2);
   endtask

   // owner match, mismatch, free slot against no-owner, out of range
   task automatic test_owner_check();
      send_item(rrsa_pkg::KIND_CHECK, 4'd0, 16'h0000, 2'd0);
      send_item(rrsa_pkg::KIND_CHECK, 4'd1, 16'h0000, 2'd0);
      send_item(rrsa_pkg::KIND_CHECK, 4'd5, 16'hffff, 2'd0);
      send_item(rrsa_pkg::KIND_CHECK, 4'd12, 16'hffff, 2'd0);
   endtask

   // fill the remaining slots, then one allocate too many
   task automatic test_table_full();
      repeat (rrsa_pkg::NUM_SLOTS - 3)
         send_item(rrsa_pkg::KIND_ALLOC, 4'($urandom), 16'($urandom),
                   2'($urandom_range(1, 2)));
      send_item(rrsa_pkg::KIND_ALLOC, 4'd0, 16'h1234, 2'd1);
   endtask

   // free twice, free out of range, then reuse the hole
   task automatic test_free_and_reuse();
      send_item(rrsa_pkg::KIND_FREE, 4'd3, 16'h0000, 2'd0);
      send_item(rrsa_pkg::KIND_FREE, 4'd3, 16'h0000, 2'd0);
      send_item(rrsa_pkg::KIND_FREE, 4'd9, 16'h0000, 2'd0);
      send_item(rrsa_pkg::KIND_ALLOC, 4'd0, 16'h4321, 2'd2);
      send_item(rrsa_pkg::KIND_QUERY, 4'd3, 16'h0000, 2'd0);
   endtask

   // random traffic with bursts of idle on the request side; idling is switched
   // on and off in stretches so some runs go back to back
   task automatic test_random_traffic(int count);
      logic idling;
      idling = 1'b1;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0)
            idling = ($urandom_range(0, 2) != 0);
         if (idling && $urandom_range(0, 4) == 0)
            hold_off($urandom_range(1, 19));
         send_random_item();
      end
   endtask

   // closing stretch with no idle at all
   task automatic test_back_to_back(int count);
      repeat (count)
         send_random_item();
   endtask

   // every strobe is checked against the oldest owed result
   always @(posedge clock) begin
      slot_rsp_type want;
      if (!reset && rsp_valid) begin
         if (owed_rsp.size() == 0) begin
            $error("result with none expected");
            mismatches++;
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_granted_slot !== want.granted) begin
               $error("granted_slot: expected %0d, got %0d", want.granted, rsp_granted_slot);
               mismatches++;
            end
            if (rsp_slot_active !== want.active) begin
               $error("slot_active: expected %0d, got %0d", want.active, rsp_slot_active);
               mismatches++;
            end
            if (rsp_slot_owner !== want.owner) begin
               $error("slot_owner: expected %0h, got %0h", want.owner, rsp_slot_owner);
               mismatches++;
            end
            if (rsp_slot_protocol !== want.proto) begin
               $error("slot_protocol: expected %0d, got %0d", want.proto, rsp_slot_protocol);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int waited;
      start = 1'b0;
      req_kind = rrsa_pkg::KIND_ALLOC;
      req_slot = '0;
      req_client = '0;
      req_protocol = rrsa_pkg::PROTO_NONE;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_contents();
      test_allocate_fields();
      test_owner_check();
      test_table_full();
      test_free_and_reuse();
      test_random_traffic(1600);
      test_back_to_back(400);
      hold_off(1);

      // drain, then give a last allocate scan time to show anything stray
      waited = 0;
      while (owed_rsp.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (rrsa_pkg::NUM_SLOTS + 4) @(posedge clock);
      if (owed_rsp.size() != 0) begin
         $error("%0d results never arrived", owed_rsp.size());
         mismatches++;
      end

      if (mismatches == 0)
         $display("round_robin_slot_allocator test passed");
      else
         $display("round_robin_slot_allocator test failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("round_robin_slot_allocator test failed");
      $finish;
   end

endmodule

// ===== round_robin_slot_allocator.f =====
rtl/rrsa_pkg.sv
rtl/rrsa_ram.sv
rtl/rrsa_scan.sv
rtl/round_robin_slot_allocator.sv
dv/round_robin_slot_allocator_tb.sv
